// File: rtl/vswr_from_fwd_ref_samples_unit_macros.svh
// ----------------------------------------------------------------------------
// VSWR unit assertion macros
// Shared concurrent assertion wrappers for the VSWR unit checkers.
// ----------------------------------------------------------------------------
`ifndef VSWR_FROM_FWD_REF_SAMPLES_UNIT_MACROS_SVH
`define VSWR_FROM_FWD_REF_SAMPLES_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define VFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define VFR_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/vfr_pkg.sv
// ----------------------------------------------------------------------------
// VSWR unit package
// Widths, status codes and the word types passed along the divider cells.
// ----------------------------------------------------------------------------
package vfr_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int LEVEL_W     = 12;
	localparam int Q_FRAC      = 16;
	localparam int GAMMA_W     = SAMPLE_BITS + Q_FRAC;
	localparam int VSWR_W      = 31;
	localparam int STATUS_W    = 2;

	// divider geometry: one quotient bit per cell
	localparam int DSR_W       = Q_FRAC;
	localparam int ACC_W       = 2 * Q_FRAC + 1;
	localparam int GAMMA_STEPS = GAMMA_W;
	localparam int VSWR_STEPS  = ACC_W;
	localparam int NUM_CELLS   = GAMMA_STEPS + VSWR_STEPS;

	localparam int S_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((GAMMA_W + VSWR_W + 7) / 8) * 8;
	localparam int M_PAD_W     = M_TDATA_W - GAMMA_W - VSWR_W;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(100);
	localparam logic [GAMMA_W-1:0] GAMMA_ONE   = GAMMA_W'(1) << Q_FRAC;
	localparam logic [GAMMA_W-1:0] GAMMA_MAX   = '1;
	localparam logic [VSWR_W-1:0]  VSWR_MAX    = '1;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID     = 2'd0,
		ST_REJECT    = 2'd1,
		ST_FWD_ZERO  = 2'd2,
		ST_GAMMA_ONE = 2'd3
	} status_t;

	// partial remainder, dividend/quotient shift word, divisor
	typedef struct packed {
		logic [DSR_W-1:0] rem;
		logic [ACC_W-1:0] acc;
		logic [DSR_W-1:0] dsr;
	} div_t;

	typedef struct packed {
		status_t            status;
		logic               out_mode;
		logic [GAMMA_W-1:0] gamma;
	} tag_t;

	typedef struct packed {
		logic valid;
		div_t d;
		tag_t tag;
	} stage_t;

endpackage

// File: rtl/vfr_cell.sv
// ----------------------------------------------------------------------------
// VSWR unit divider cell
// One restoring division step with its own word register and handshake.
// ----------------------------------------------------------------------------
module vfr_cell
	import vfr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t up,
	output logic   up_ready,
	output stage_t dn,
	input  logic   dn_ready
);

	logic             valid_q;
	div_t             d_q;
	tag_t             tag_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   dsr_ext;
	logic [DSR_W:0]   diff;
	logic             ge;
	logic             load;

	assign up_ready = !valid_q || dn_ready;
	assign load     = up.valid && up_ready;

	// shift next dividend bit into the remainder, subtract if it fits
	assign trial   = {up.d.rem, up.d.acc[ACC_W-1]};
	assign dsr_ext = {1'b0, up.d.dsr};
	assign diff    = trial - dsr_ext;
	assign ge      = trial >= dsr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_q.rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			d_q.acc <= {up.d.acc[ACC_W-2:0], ge};
			d_q.dsr <= up.d.dsr;
			tag_q   <= up.tag;
		end
	end

	assign dn.valid = valid_q;
	assign dn.d     = d_q;
	assign dn.tag   = tag_q;

endmodule

// File: rtl/vfr_front.sv
// ----------------------------------------------------------------------------
// VSWR unit front stage
// Holds the level register, sorts out special cases, loads the gamma divider.
// ----------------------------------------------------------------------------
module vfr_front
	import vfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [LEVEL_W-1:0]     cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic                   sample_fresh,
	input  logic [SAMPLE_BITS-1:0] fwd_sample,
	input  logic [SAMPLE_BITS-1:0] refl_sample,
	output stage_t                 dn,
	input  logic                   dn_ready
);

	logic [LEVEL_W-1:0] min_level_q;
	logic               valid_q;
	div_t               d_q;
	tag_t               tag_q;
	status_t            status;
	logic               fwd_zero;

	assign in_ready = !valid_q || dn_ready;
	assign fwd_zero = (fwd_sample == '0);

	// gamma == 0 iff refl is zero, gamma == 1 iff refl equals fwd
	always_comb begin
		if (!sample_fresh) begin
			status = ST_REJECT;
		end else if (!mode) begin
			status = fwd_zero ? ST_FWD_ZERO : ST_VALID;
		end else if (refl_sample > fwd_sample || LEVEL_W'(fwd_sample) < min_level_q) begin
			status = ST_REJECT;
		end else if (fwd_zero) begin
			status = ST_FWD_ZERO;
		end else if (refl_sample == '0) begin
			status = ST_REJECT;
		end else if (refl_sample == fwd_sample) begin
			status = ST_GAMMA_ONE;
		end else begin
			status = ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= LEVEL_RESET;
			valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_level_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_q.rem          <= '0;
			d_q.acc          <= {refl_sample, {(ACC_W-SAMPLE_BITS){1'b0}}};
			d_q.dsr          <= {{(DSR_W-SAMPLE_BITS){1'b0}}, fwd_sample};
			tag_q.status     <= status;
			tag_q.out_mode   <= mode;
			tag_q.gamma      <= '0;
		end
	end

	assign dn.valid = valid_q;
	assign dn.d     = d_q;
	assign dn.tag   = tag_q;

endmodule

// File: rtl/vfr_back.sv
// ----------------------------------------------------------------------------
// VSWR unit output stage
// Picks result fields by status, saturates VSWR, holds the output word.
// ----------------------------------------------------------------------------
module vfr_back
	import vfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  stage_t               up,
	output logic                 up_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [GAMMA_W-1:0]   gamma_q16,
	output logic [VSWR_W-1:0]    vswr_q16,
	output logic [STATUS_W-1:0]  status
);

	logic                valid_q;
	logic [GAMMA_W-1:0]  gamma_q;
	logic [VSWR_W-1:0]   vswr_q;
	status_t             status_q;
	logic [GAMMA_W-1:0]  gamma_n;
	logic [VSWR_W-1:0]   vswr_n;
	logic [VSWR_W-1:0]   vswr_sat;

	assign up_ready = !valid_q || out_ready;

	assign vswr_sat = (up.d.acc[ACC_W-1:VSWR_W] != '0) ? VSWR_MAX : up.d.acc[VSWR_W-1:0];

	always_comb begin
		case (up.tag.status)
			ST_VALID: begin
				gamma_n = up.tag.gamma;
				vswr_n  = up.tag.out_mode ? vswr_sat : '0;
			end
			ST_REJECT: begin
				gamma_n = '0;
				vswr_n  = '0;
			end
			ST_FWD_ZERO: begin
				gamma_n = GAMMA_MAX;
				vswr_n  = up.tag.out_mode ? VSWR_MAX : '0;
			end
			ST_GAMMA_ONE: begin
				gamma_n = GAMMA_ONE;
				vswr_n  = VSWR_MAX;
			end
			default: begin
				gamma_n = '0;
				vswr_n  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid && up_ready) begin
			gamma_q  <= gamma_n;
			vswr_q   <= vswr_n;
			status_q <= up.tag.status;
		end
	end

	assign out_valid = valid_q;
	assign gamma_q16 = gamma_q;
	assign vswr_q16  = vswr_q;
	assign status    = status_q;

endmodule

// File: rtl/vswr_from_fwd_ref_samples_unit.sv
// ----------------------------------------------------------------------------
// VSWR from forward / reflected samples
// Reflection coefficient gamma = floor(refl * 2^16 / fwd) in Q16 and, with
// the known load switched out, VSWR = (1 + gamma) / (1 - gamma) in Q16.
//
//   port group   dir   word contents (low bit first)
//   s_*          in    tdata: fwd[11:0], refl[23:12]; tuser: mode, sample_fresh
//   m_*          out   tdata: gamma_q16[27:0], vswr_q16[58:28], zero pad;
//                      tuser: status
//   cfg_*        in    min_forward_level, written when cfg_we is high
//
// One word per cycle sustained while m_tready holds; each word passes the front stage,
// 28 gamma cells, 33 VSWR cells and the output register. The cell chain forms one
// restoring quotient bit per cell.
// Every cell has its own valid and a ready that looks one cell ahead, so a
// stalled output fills bubbles first and input keeps flowing until the chain
// is full.
// arst_n clears all valid bits and loads min_forward_level with 100.
// ----------------------------------------------------------------------------
module vswr_from_fwd_ref_samples_unit
	import vfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config
	input  logic                  cfg_we,
	input  logic [LEVEL_W-1:0]    cfg_wdata,  // min_forward_level
	// sample pairs
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,    // forward_sample, reflected_sample
	input  logic [1:0]            s_tuser,    // mode, sample_fresh
	// results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,    // gamma_q16, vswr_q16, zero pad
	output logic [STATUS_W-1:0]   m_tuser     // status
);

	stage_t              front_dn;
	logic                front_dn_ready;
	stage_t              cell_up   [NUM_CELLS];
	stage_t              cell_dn   [NUM_CELLS];
	logic                cell_up_ready [NUM_CELLS];
	logic                cell_dn_ready [NUM_CELLS];
	stage_t              vswr_load;
	logic [Q_FRAC-1:0]   gamma_frac;
	logic                back_ready;
	logic [GAMMA_W-1:0]  gamma_q16;
	logic [VSWR_W-1:0]   vswr_q16;

	// input classification and gamma dividend/divisor load
	vfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.mode         (s_tuser[0]),
		.sample_fresh (s_tuser[1]),
		.fwd_sample   (s_tdata[SAMPLE_BITS-1:0]),
		.refl_sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.dn           (front_dn),
		.dn_ready     (front_dn_ready)
	);

	assign front_dn_ready = cell_up_ready[0];

	// Gamma leaves the last gamma cell in the low bits of the shift word.
	// For the VSWR pass, dividend is (1 + gamma) << 16 and divisor 1 - gamma;
	// both only matter when 0 < gamma < 1, so the low 16 bits suffice.
	assign gamma_frac = cell_dn[GAMMA_STEPS-1].d.acc[Q_FRAC-1:0];

	always_comb begin
		vswr_load           = cell_dn[GAMMA_STEPS-1];
		vswr_load.tag.gamma = cell_dn[GAMMA_STEPS-1].d.acc[GAMMA_W-1:0];
		vswr_load.d.rem     = '0;
		vswr_load.d.acc     = {1'b1, gamma_frac, {Q_FRAC{1'b0}}};
		vswr_load.d.dsr     = ~gamma_frac + DSR_W'(1);
	end

	// divider chain: cells 0..27 form gamma, cells 28..60 form VSWR
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign cell_up[i] = front_dn;
		end else if (i == GAMMA_STEPS) begin : g_join
			assign cell_up[i] = vswr_load;
		end else begin : g_mid
			assign cell_up[i] = cell_dn[i-1];
		end

		if (i == NUM_CELLS - 1) begin : g_last
			assign cell_dn_ready[i] = back_ready;
		end else begin : g_next
			assign cell_dn_ready[i] = cell_up_ready[i+1];
		end

		vfr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up       (cell_up[i]),
			.up_ready (cell_up_ready[i]),
			.dn       (cell_dn[i]),
			.dn_ready (cell_dn_ready[i])
		);
	end

	// field selection, saturation and the output register
	vfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.up        (cell_dn[NUM_CELLS-1]),
		.up_ready  (back_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.gamma_q16 (gamma_q16),
		.vswr_q16  (vswr_q16),
		.status    (m_tuser)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, vswr_q16, gamma_q16};

endmodule

// File: rtl/vfr_checker.sv
// ----------------------------------------------------------------------------
// VSWR unit port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "vswr_from_fwd_ref_samples_unit_macros.svh"

module vfr_checker
	import vfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic [STATUS_W-1:0]   m_tuser
);

	logic [GAMMA_W-1:0] gamma;
	logic [VSWR_W-1:0]  vswr;

	assign gamma = m_tdata[GAMMA_W-1:0];
	assign vswr  = m_tdata[GAMMA_W+VSWR_W-1:GAMMA_W];

	`VFR_ASSERT_RST(a_no_valid_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")

	`VFR_ASSERT(a_hold_on_stall,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"stalled result word changed")

	`VFR_ASSERT(a_reject_zero,
		m_tvalid && m_tuser == ST_REJECT |-> gamma == '0 && vswr == '0,
		"rejected result carries nonzero fields")

	`VFR_ASSERT(a_gamma_one,
		m_tvalid && m_tuser == ST_GAMMA_ONE |-> gamma == GAMMA_ONE && vswr == VSWR_MAX,
		"gamma-one result not saturated")

	`VFR_ASSERT(a_vswr_range,
		m_tvalid && m_tuser == ST_VALID && vswr != '0 |-> gamma != '0 && gamma < GAMMA_ONE,
		"VSWR given for gamma outside (0, 1)")

endmodule

bind vswr_from_fwd_ref_samples_unit vfr_checker u_vfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// VSWR unit testbench
// Streams forward/reflected sample pairs into the unit and checks each
// gamma / VSWR / status word against a behavioral prediction of the
// divider math. The run steps min_forward_level through several values,
// from zero to full scale. Both sides stall at random. One long output
// hold-off lets the cell chain fill and back up its input.
// ----------------------------------------------------------------------------
module tb_top;
	import vfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int PIPE_LATENCY  = 63;    // front stage + 61 cells + output reg
	localparam int HOLD_CYCLES   = 200;   // well past the chain depth
	localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
	localparam int PRINT_LIMIT   = 100;
	localparam logic [63:0] Q16_UNITY = 64'd1 << Q_FRAC;

	// one input word as the sender sees it
	typedef struct packed {
		logic                   mode;    // 1 = known load switched out
		logic                   fresh;
		logic [SAMPLE_BITS-1:0] fwd;
		logic [SAMPLE_BITS-1:0] refl;
	} sample_word_t;

	typedef struct packed {
		logic [GAMMA_W-1:0] gamma;
		logic [VSWR_W-1:0]  vswr;
		status_t            status;
	} vswr_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b1;
	logic                 cfg_we    = 1'b0;
	logic [LEVEL_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// predictor copy of the threshold register
	logic [LEVEL_W-1:0]   level_model = LEVEL_RESET;

	sample_word_t pending_words[$];
	vswr_result_t expected_results[$];
	int           words_queued = 0;
	int           words_sent   = 0;
	int           results_seen = 0;
	int           mismatches   = 0;
	logic         s_fire       = 1'b0;

	// idling controls, set per phase
	bit sender_calm   = 1'b0;
	bit receiver_calm = 1'b0;
	bit hold_go       = 1'b0;
	bit hold_done     = 1'b0;
	int send_gap      = 0;
	int ready_gap     = 0;
	int hold_left     = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	vswr_from_fwd_ref_samples_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// gamma = floor(refl * 2^16 / fwd); switched-out mode screens the pair
	// first and adds VSWR = (1 + gamma) / (1 - gamma), both in Q16
	function automatic vswr_result_t measure_vswr(input sample_word_t w,
			input logic [LEVEL_W-1:0] level);
		vswr_result_t r;
		logic [63:0]  fwd;
		logic [63:0]  refl;
		logic [63:0]  quot;
		logic [63:0]  ratio;
		r.gamma  = '0;
		r.vswr   = '0;
		r.status = ST_REJECT;
		fwd      = 64'(w.fwd);
		refl     = 64'(w.refl);
		if (!w.fresh)
			return r;
		if (!w.mode) begin
			// switched in: no screening, VSWR stays zero
			if (fwd == 0) begin
				r.gamma  = GAMMA_MAX;
				r.status = ST_FWD_ZERO;
			end else begin
				quot = (refl << Q_FRAC) / fwd;
				if (quot > 64'(GAMMA_MAX))
					quot = 64'(GAMMA_MAX);
				r.gamma  = quot[GAMMA_W-1:0];
				r.status = ST_VALID;
			end
			return r;
		end
		if (refl > fwd || fwd < 64'(level))
			return r;
		if (fwd == 0) begin
			r.gamma  = GAMMA_MAX;
			r.vswr   = VSWR_MAX;
			r.status = ST_FWD_ZERO;
			return r;
		end
		quot = (refl << Q_FRAC) / fwd;
		if (quot == 0)
			return r;
		if (quot >= Q16_UNITY) begin
			r.gamma  = GAMMA_ONE;
			r.vswr   = VSWR_MAX;
			r.status = ST_GAMMA_ONE;
			return r;
		end
		ratio = ((Q16_UNITY + quot) << Q_FRAC) / (Q16_UNITY - quot);
		if (ratio > 64'(VSWR_MAX))
			ratio = 64'(VSWR_MAX);
		r.gamma  = quot[GAMMA_W-1:0];
		r.vswr   = ratio[VSWR_W-1:0];
		r.status = ST_VALID;
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit calm);
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 60)
			return 0;
		if (k < 88)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns result %0d: %s got 0x%0h, want 0x%0h",
				$realtime, results_seen, what, got, want);
	endtask

	task automatic queue_word(input bit mode, input bit fresh, input int fwd,
			input int refl);
		sample_word_t w;
		w.mode  = mode;
		w.fresh = fresh;
		w.fwd   = fwd[SAMPLE_BITS-1:0];
		w.refl  = refl[SAMPLE_BITS-1:0];
		pending_words.push_back(w);
		words_queued++;
	endtask

	// mostly plausible switched-out pairs against the current threshold,
	// the rest stale, switched-in or unscreened noise
	task automatic queue_random(input int count);
		sample_word_t w;
		int k;
		int sub;
		int fwd;
		int refl;
		for (int i = 0; i < count; i++) begin
			k    = $urandom_range(0, 99);
			sub  = $urandom_range(0, 9);
			w    = sample_word_t'($urandom);
			w.fresh = 1'b1;
			fwd  = w.fwd;
			refl = w.refl;
			if (k < 8)
				w.fresh = 1'b0;
			else if (k < 28)
				w.mode = (k < 18) ? w.mode : 1'b0;
			else begin
				w.mode = 1'b1;
				if (k < 36)
					fwd = $urandom_range(0, 255);
				else
					fwd = $urandom_range(int'(level_model), 4095);
				case (sub)
					0: refl = fwd;
					1: refl = 0;
					2: refl = (fwd > 3) ? fwd - $urandom_range(1, 3) : fwd;
					3: refl = fwd + 1;
					default: refl = $urandom_range(0, fwd);
				endcase
				w.fwd  = fwd[SAMPLE_BITS-1:0];
				w.refl = refl[SAMPLE_BITS-1:0];
			end
			pending_words.push_back(w);
			words_queued++;
		end
	endtask

	// every word out and every result back
	task automatic wait_drained();
		while (words_sent != words_queued || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_level(input logic [LEVEL_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		level_model = value;
	endtask

	// sender: next word goes out at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (!s_tvalid || s_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {pending_words[0].refl, pending_words[0].fwd};
				s_tuser  <= {pending_words[0].fresh, pending_words[0].mode};
				void'(pending_words.pop_front());
				send_gap = pick_gap(sender_calm);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// accepted input word -> prediction
	always @(posedge clk) begin : accept_side
		sample_word_t w;
		s_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			w.mode  = s_tuser[0];
			w.fresh = s_tuser[1];
			w.fwd   = s_tdata[SAMPLE_BITS-1:0];
			w.refl  = s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
			expected_results.push_back(measure_vswr(w, level_model));
			words_sent++;
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			ready_gap = pick_gap(receiver_calm);
		end
	end

	// result check, oldest prediction first
	always @(posedge clk) begin : result_side
		vswr_result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0)
				report_mismatch("unexpected result word", 64'(m_tdata), 64'd0);
			else begin
				want = expected_results.pop_front();
				if (m_tdata[GAMMA_W-1:0] !== want.gamma)
					report_mismatch("gamma_q16", 64'(m_tdata[GAMMA_W-1:0]),
						64'(want.gamma));
				if (m_tdata[GAMMA_W +: VSWR_W] !== want.vswr)
					report_mismatch("vswr_q16", 64'(m_tdata[GAMMA_W +: VSWR_W]),
						64'(want.vswr));
				if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
					report_mismatch("tdata pad", 64'(m_tdata[M_TDATA_W-1 -: M_PAD_W]),
						64'd0);
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
			end
		end
	end

	// no handshake on either side for too long ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		// a real falling edge on arst_n, ahead of the first clock edge
		#1 arst_n = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// threshold at its reset value
		queue_word(0, 0, 4095, 4095);   // stale, switched in
		queue_word(1, 0, 2000, 1000);   // stale, switched out
		queue_word(0, 1, 0, 4095);      // forward zero, switched in
		queue_word(0, 1, 0, 0);
		queue_word(0, 1, 1, 4095);      // largest gamma
		queue_word(0, 1, 4095, 0);      // gamma zero is fine when switched in
		queue_word(0, 1, 1000, 3000);   // reflected above forward, no screening
		queue_word(1, 1, 1000, 1001);   // reflected above forward
		queue_word(1, 1, 99, 10);       // forward just under threshold
		queue_word(1, 1, 100, 50);      // forward right at threshold
		queue_word(1, 1, 2000, 0);      // gamma zero rejected
		queue_word(1, 1, 4095, 4095);   // gamma one
		queue_word(1, 1, 4095, 4094);   // gamma just below one, largest VSWR
		queue_word(1, 1, 4095, 1);      // smallest nonzero gamma
		queue_word(1, 1, 0, 0);         // forward zero caught by threshold
		queue_word(1, 1, 2048, 1365);
		wait_drained();

		// threshold off: forward zero gets through the screen
		write_level('0);
		queue_word(1, 1, 0, 0);
		queue_word(1, 1, 1, 1);
		queue_word(1, 1, 1, 0);
		queue_random(200);
		wait_drained();

		// full scale threshold: only forward 4095 passes
		write_level('1);
		queue_word(1, 1, 4094, 10);
		queue_word(1, 1, 4095, 2000);
		queue_random(150);
		wait_drained();

		// sender flat out while the receiver holds off
		write_level(LEVEL_W'($urandom));
		sender_calm = 1'b1;
		hold_go     = 1'b1;
		queue_random(300);
		wait_drained();

		// no idling on either side
		write_level(LEVEL_W'($urandom));
		receiver_calm = 1'b1;
		queue_random(200);
		wait_drained();
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;

		write_level(LEVEL_W'($urandom_range(0, 255)));
		queue_random(400);
		wait_drained();

		// anything left in the chain would show up here
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
